/* hw/rtl/integer_to_ascii_radix_macros.svh */
// Assertion macros for the integer to ASCII converter.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define I2A_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define I2A_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/i2a_pkg.sv */
// Shared types, codes and helpers of the integer to ASCII converter.
package i2a_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;

  typedef enum logic [1:0] {
    CMD_DEC = 2'd0,
    CMD_HEX = 2'd1,
    CMD_BIN = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // Classified request as it travels through the queue (magnitude goes alongside).
  typedef struct packed {
    cmd_e cmd;
    logic neg;
  } ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BCD,
    BK_SIGN,
    BK_PFX0,
    BK_PFX1,
    BK_DIGITS
  } back_state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0000, d};
    end else begin
      ch = CH_LOW_A + {4'b0000, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

/* hw/rtl/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII converter: front end, request queue, back end.

// Converts a signed VALUE_WIDTH-bit integer to ASCII text, one character per
// result request, with last set on the final character. Command DEC prints an
// optional '-' and the decimal magnitude (the most negative value prints its full
// magnitude); HEX prints "0x" and BIN prints "0b", then the two's complement
// pattern in lowercase digits. Leading zeros are suppressed; zero prints a single
// '0' after any prefix. Requests with command 3 are dropped and produce nothing.
// Flow: the front end takes a request in any cycle in which the two-entry
// queue has room, so up to two requests can wait while one is converted. The
// back end works on one request at a time: it takes it from the queue, then for
// decimal runs VALUE_WIDTH steps of binary-to-BCD conversion (one
// shift-and-adjust step a cycle), emits the sign if negative, and then works
// through the floor(VALUE_WIDTH*0.30103)+1 BCD digit positions, emitting each
// or dropping it as a leading zero. Hex emits "0x" and then works through
// ceil(VALUE_WIDTH/4) digit positions, binary "0b" and then VALUE_WIDTH digit
// positions; digit positions go at one per cycle while the result channel does
// not stall. A registered output stage parts the back end from the result
// channel, so a stalled consumer holds the back end only when the next character
// is ready; leading-zero positions are dropped even while stalled.

`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2a_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output i2a_pkg::out_item_t out_item
);

  localparam int Q_DATA_W = $bits(i2a_pkg::ctl_t) + VALUE_WIDTH;

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  i2a_pkg::ctl_t          push_ctl;
  logic [VALUE_WIDTH-1:0] push_mag;
  i2a_pkg::ctl_t          pop_ctl;
  logic [VALUE_WIDTH-1:0] pop_mag;
  logic [Q_DATA_W-1:0]    q_rd_data;

  // Classify the request: drop unused commands, split sign from magnitude.
  i2a_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ctl    (push_ctl),
    .q_mag    (push_mag)
  );

  // Hold classified requests so the front keeps accepting while text streams out.
  i2a_queue #(
    .DATA_W(Q_DATA_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({push_ctl, push_mag}),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  assign pop_ctl = i2a_pkg::ctl_t'(q_rd_data[Q_DATA_W-1:VALUE_WIDTH]);
  assign pop_mag = q_rd_data[VALUE_WIDTH-1:0];

  // Convert and stream characters through the output register.
  i2a_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ctl     (pop_ctl),
    .q_mag     (pop_mag),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // The back end only takes from a non-empty queue.
  `I2A_CHECK_NOW(a_pop_nonempty, q_pop, q_valid, "request taken from empty queue")

  // One request at a time: a take is never followed by another take.
  `I2A_CHECK_NEXT(a_pop_spaced, q_pop, !q_pop, "back end took two requests in a row")

  // Every accepted request with a known command reaches the queue.
  `I2A_CHECK_NOW(a_push_known,
    in_valid && in_ready && (in_item.command == i2a_pkg::CMD_DEC
      || in_item.command == i2a_pkg::CMD_HEX || in_item.command == i2a_pkg::CMD_BIN),
    q_push, "accepted request not queued")

  // Every character sent is printable text, never a null byte.
  `I2A_CHECK_NOW(a_char_nonzero, out_valid, out_item.character != 8'h00,
    "null character on result channel")

endmodule

/* hw/rtl/i2a_front.sv */
// Front end: accepts requests, drops unused commands, forms sign and magnitude.
module i2a_front #(
  parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  i2a_pkg::in_item_t        in_item,
  input  logic                     q_full,
  output logic                     q_push,
  output i2a_pkg::ctl_t            q_ctl,
  output logic [VALUE_WIDTH-1:0]   q_mag
);

  logic [VALUE_WIDTH-1:0] pattern;
  logic                   is_dec;
  logic                   known_cmd;

  assign pattern   = in_item.value[VALUE_WIDTH-1:0];
  assign is_dec    = in_item.command == i2a_pkg::CMD_DEC;
  assign known_cmd = is_dec || in_item.command == i2a_pkg::CMD_HEX
                     || in_item.command == i2a_pkg::CMD_BIN;

  assign in_ready = !q_full;
  // Drop requests with an unused command: they produce no text.
  assign q_push   = in_valid && !q_full && known_cmd;

  always_comb begin
    q_ctl.cmd = i2a_pkg::cmd_e'(in_item.command);
    q_ctl.neg = is_dec && pattern[VALUE_WIDTH-1];
    if (q_ctl.neg) begin
      q_mag = (~pattern) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      q_mag = pattern;
    end
  end

endmodule

/* hw/rtl/i2a_queue.sv */
// Short request queue between front and back end.
module i2a_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = i2a_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign valid   = count_r != '0;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/i2a_back.sv */
// Back end: converts one request to text and streams it through an output register.
module i2a_back #(
  parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  i2a_pkg::ctl_t          q_ctl,
  input  logic [VALUE_WIDTH-1:0] q_mag,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2a_pkg::out_item_t     out_item
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DEC_W      = 4 * DEC_DIGITS;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_W      = 4 * HEX_DIGITS;
  localparam int DIG_W      = DEC_W;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  i2a_pkg::back_state_e   state_r, state_nxt;
  i2a_pkg::cmd_e          cmd_r, cmd_nxt;
  logic                   neg_r, neg_nxt;
  logic                   started_r, started_nxt;
  logic [VALUE_WIDTH-1:0] shift_r, shift_nxt;
  logic [DIG_W-1:0]       dig_r, dig_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  i2a_pkg::out_item_t     out_item_r, out_item_nxt;

  logic                   can_load;
  logic                   load;
  logic [3:0]             dig_top;
  logic [DIG_W-1:0]       dig_shift;
  logic [DEC_W-1:0]       bcd_adj;
  logic                   last_digit;

  assign can_load   = !out_valid_r || out_ready;
  assign last_digit = cnt_r == CNT_W'(1);
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  always_comb begin
    if (cmd_r == i2a_pkg::CMD_BIN) begin
      dig_top   = {3'b000, dig_r[DIG_W-1]};
      dig_shift = dig_r << 1;
    end else begin
      dig_top   = dig_r[DIG_W-1 -: 4];
      dig_shift = dig_r << 4;
    end
    // Add three to every BCD digit of five or more before the shift.
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    neg_nxt      = neg_r;
    started_nxt  = started_r;
    shift_nxt    = shift_r;
    dig_nxt      = dig_r;
    cnt_nxt      = cnt_r;
    out_item_nxt = out_item_r;
    q_pop        = 1'b0;
    load         = 1'b0;
    unique case (state_r)
      i2a_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_ctl.cmd;
          neg_nxt     = q_ctl.neg;
          started_nxt = 1'b0;
          shift_nxt   = q_mag;
          if (q_ctl.cmd == i2a_pkg::CMD_DEC) begin
            dig_nxt   = '0;
            cnt_nxt   = CNT_W'(VALUE_WIDTH);
            state_nxt = i2a_pkg::BK_BCD;
          end else if (q_ctl.cmd == i2a_pkg::CMD_HEX) begin
            dig_nxt   = DIG_W'(q_mag) << (DIG_W - HEX_W);
            cnt_nxt   = CNT_W'(HEX_DIGITS);
            state_nxt = i2a_pkg::BK_PFX0;
          end else begin
            dig_nxt   = DIG_W'(q_mag) << (DIG_W - VALUE_WIDTH);
            cnt_nxt   = CNT_W'(VALUE_WIDTH);
            state_nxt = i2a_pkg::BK_PFX0;
          end
        end
      end
      i2a_pkg::BK_BCD: begin
        dig_nxt   = {bcd_adj[DEC_W-2:0], shift_r[VALUE_WIDTH-1]};
        shift_nxt = shift_r << 1;
        if (last_digit) begin
          cnt_nxt   = CNT_W'(DEC_DIGITS);
          state_nxt = neg_r ? i2a_pkg::BK_SIGN : i2a_pkg::BK_DIGITS;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      i2a_pkg::BK_SIGN: begin
        if (can_load) begin
          load         = 1'b1;
          out_item_nxt = '{character: i2a_pkg::CH_MINUS, last: 1'b0};
          state_nxt    = i2a_pkg::BK_DIGITS;
        end
      end
      i2a_pkg::BK_PFX0: begin
        if (can_load) begin
          load         = 1'b1;
          out_item_nxt = '{character: i2a_pkg::CH_ZERO, last: 1'b0};
          state_nxt    = i2a_pkg::BK_PFX1;
        end
      end
      i2a_pkg::BK_PFX1: begin
        if (can_load) begin
          load         = 1'b1;
          out_item_nxt = '{character: (cmd_r == i2a_pkg::CMD_HEX) ? i2a_pkg::CH_X
                                                                   : i2a_pkg::CH_B,
                            last: 1'b0};
          state_nxt    = i2a_pkg::BK_DIGITS;
        end
      end
      i2a_pkg::BK_DIGITS: begin
        if (dig_top == 4'd0 && !started_r && !last_digit) begin
          // Drop a leading zero without emitting it.
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (can_load) begin
          load         = 1'b1;
          out_item_nxt = '{character: i2a_pkg::digit_char(dig_top), last: last_digit};
          dig_nxt      = dig_shift;
          cnt_nxt      = cnt_r - CNT_W'(1);
          started_nxt  = 1'b1;
          if (last_digit) begin
            state_nxt = i2a_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = i2a_pkg::BK_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2a_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    neg_r      <= neg_nxt;
    started_r  <= started_nxt;
    shift_r    <= shift_nxt;
    dig_r      <= dig_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
